/* hw/rtl/rpa_pkg.sv */
// rpa_pkg: shared sizes, operation and status codes, and helpers for the
// refcounted page allocator. No dependencies; used by refcounted_page_allocator.
package rpa_pkg;

	// Memory geometry
	localparam int ADDR_W     = 32;
	localparam int PAGE_SHIFT = 12;
	localparam int MEM_PAGES  = 32768;
	localparam int BASE_PAGE  = 524288;

	// Derived widths
	localparam int IDX_W   = $clog2(MEM_PAGES);
	localparam int DEPTH_W = $clog2(MEM_PAGES + 1);
	localparam int CNT_W   = 16;
	localparam int XW      = ADDR_W + 1;

	localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
	localparam logic [XW-1:0]      BASE_X    = XW'(BASE_PAGE);
	localparam logic [XW-1:0]      PAGES_X   = XW'(MEM_PAGES);
	localparam logic [DEPTH_W-1:0] STACK_MAX = DEPTH_W'(MEM_PAGES);
	localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(MEM_PAGES - 1);
	localparam logic [ADDR_W-1:0]  KEND_RST  = 32'h8000_0000;

	typedef enum logic [1:0] {
		FN_ALLOC   = 2'd0,
		FN_RELEASE = 2'd1,
		FN_SHARE   = 2'd2,
		FN_QUERY   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_NO_PAGE  = 2'd1,
		STS_BAD_ADDR = 2'd2,
		STS_ZERO     = 2'd3
	} status_t;

	// Lowest page number allocation may reach: kernel end rounded up to a page
	function automatic logic [XW-1:0] floor_page(input logic [ADDR_W-1:0] kend);
		return XW'(kend[ADDR_W-1:PAGE_SHIFT]) + XW'(|kend[PAGE_SHIFT-1:0]);
	endfunction

	// Byte address of a page index, modulo 2^ADDR_W
	function automatic logic [ADDR_W-1:0] page_addr(input logic [IDX_W-1:0] idx);
		logic [XW-1:0] pg;
		pg = BASE_X + XW'(idx);
		return ADDR_W'(pg << PAGE_SHIFT);
	endfunction

endpackage

/* hw/rtl/rpa_ram.sv */
// rpa_ram: generic simple dual-port RAM, one write and one registered read
// port. No dependencies.
module rpa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/refcounted_page_allocator.sv */
// refcounted_page_allocator: top level of the physical page allocator.
// Depends on rpa_pkg and rpa_ram (share count store and free page stack).
//
// Usage:
//  - Input channel (in_valid/in_ready) carries func and page_address. Func
//    selects allocate, release, share (count up) or query.
//  - Output channel (out_valid/out_ready) returns one beat per input beat:
//    status, result_address, share_count, page_released.
//  - Config channel (cfg_valid/cfg_ready, cfg_data) writes kernel_end; it is
//    always ready. The user must see that it is only written while the
//    block is idle; the block itself does not enforce this.
//  - Each item is accepted in idle, which issues the count store and stack
//    reads; then in execute the count is modified and written back and the
//    output register is loaded. The registered read of the count store sets
//    this, so the block takes no new item until the last one leaves execute.
//  - The result beat is valid in the cycle after the execute cycle.
//  - If the receiver stalls while a result is held, the next item is still
//    accepted and read; it waits in execute until the output register frees.
//  - After reset the share count store is cleared by a pass over all
//    MEM_PAGES (32768) entries, one entry per cycle; in_ready stays low meanwhile.
module refcounted_page_allocator (
	input  logic                      clk,
	input  logic                      arst_n,
	// config
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [rpa_pkg::ADDR_W-1:0] cfg_data,
	// input beats
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                func,
	input  logic [rpa_pkg::ADDR_W-1:0] page_address,
	// result beats
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                status,
	output logic [rpa_pkg::ADDR_W-1:0] result_address,
	output logic [rpa_pkg::CNT_W-1:0]  share_count,
	output logic                      page_released
);

	typedef enum logic [2:0] {
		S_CLEAR = 3'b001,
		S_IDLE  = 3'b010,
		S_EXEC  = 3'b100
	} state_t;

	state_t state_q;

	// configuration and allocator state
	logic [rpa_pkg::ADDR_W-1:0]  kernel_end_q;
	logic [rpa_pkg::XW-1:0]      floor_q;
	logic [rpa_pkg::DEPTH_W-1:0] stack_depth_q;
	logic [rpa_pkg::IDX_W-1:0]   next_untouched_q;
	logic                        untouched_left_q;
	logic [rpa_pkg::IDX_W-1:0]   clr_q;

	// item captured at accept
	rpa_pkg::func_t              func_s1;
	logic [rpa_pkg::IDX_W-1:0]   idx_s1;
	logic                        bad_s1;
	logic                        from_stack_s1;
	logic                        untouched_ok_s1;

	// output register
	logic                        out_valid_q;
	logic [1:0]                  status_q;
	logic [rpa_pkg::ADDR_W-1:0]  result_address_q;
	logic [rpa_pkg::CNT_W-1:0]   share_count_q;
	logic                        page_released_q;

	// memory ports
	logic                        cnt_we;
	logic [rpa_pkg::IDX_W-1:0]   cnt_waddr;
	logic [rpa_pkg::CNT_W-1:0]   cnt_wdata;
	logic [rpa_pkg::CNT_W-1:0]   cnt_rdata;
	logic                        stk_we;
	logic [rpa_pkg::IDX_W-1:0]   stk_waddr;
	logic [rpa_pkg::IDX_W-1:0]   stk_raddr;
	logic [rpa_pkg::IDX_W-1:0]   stk_rdata;

	// accept-side decode
	logic                        in_fire;
	rpa_pkg::func_t              func_in;
	logic [rpa_pkg::XW-1:0]      pg_x;
	logic [rpa_pkg::XW-1:0]      off_x;
	logic                        in_mem;
	logic                        rel_bad;
	logic [rpa_pkg::IDX_W-1:0]   idx_in;
	logic [rpa_pkg::DEPTH_W-1:0] depth_dec;
	logic [rpa_pkg::XW-1:0]      top_x;

	// execute-side results
	logic                        exec_fire;
	logic                        ex_we;
	logic [rpa_pkg::IDX_W-1:0]   ex_idx;
	logic [rpa_pkg::CNT_W-1:0]   ex_wdata;
	rpa_pkg::status_t            ex_status;
	logic [rpa_pkg::ADDR_W-1:0]  ex_raddr;
	logic [rpa_pkg::CNT_W-1:0]   ex_cnt;
	logic                        ex_rel;
	logic                        ex_push;
	logic                        ex_pop;
	logic                        ex_take;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign exec_fire = (state_q == S_EXEC) && (!out_valid_q || out_ready);

	// address decode of the incoming beat
	always_comb begin
		func_in   = rpa_pkg::func_t'(func);
		pg_x      = rpa_pkg::XW'(page_address[rpa_pkg::ADDR_W-1:rpa_pkg::PAGE_SHIFT]);
		off_x     = pg_x - rpa_pkg::BASE_X;
		in_mem    = (pg_x >= rpa_pkg::BASE_X) && (off_x < rpa_pkg::PAGES_X);
		idx_in    = off_x[rpa_pkg::IDX_W-1:0];
		rel_bad   = (|page_address[rpa_pkg::PAGE_SHIFT-1:0]) ||
			(page_address < kernel_end_q) || !in_mem;
		depth_dec = stack_depth_q - rpa_pkg::DEPTH_W'(1);
		stk_raddr = depth_dec[rpa_pkg::IDX_W-1:0];
		top_x     = rpa_pkg::BASE_X + rpa_pkg::XW'(next_untouched_q);
	end

	// capture the item
	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_s1         <= func_in;
			idx_s1          <= idx_in;
			bad_s1          <= (func_in == rpa_pkg::FN_RELEASE) ? rel_bad : !in_mem;
			from_stack_s1   <= (stack_depth_q != '0);
			untouched_ok_s1 <= untouched_left_q && (top_x >= floor_q);
		end
	end

	// read-modify-write of the count, stack push or pop
	always_comb begin
		ex_we     = 1'b0;
		ex_idx    = idx_s1;
		ex_wdata  = cnt_rdata;
		ex_status = rpa_pkg::STS_OK;
		ex_raddr  = '0;
		ex_cnt    = '0;
		ex_rel    = 1'b0;
		ex_push   = 1'b0;
		ex_pop    = 1'b0;
		ex_take   = 1'b0;
		case (func_s1)
			rpa_pkg::FN_ALLOC: begin
				if (from_stack_s1) begin
					ex_pop = 1'b1;
					ex_idx = stk_rdata;
				end else if (untouched_ok_s1) begin
					ex_take = 1'b1;
					ex_idx  = next_untouched_q;
				end
				if (ex_pop || ex_take) begin
					ex_we    = 1'b1;
					ex_wdata = rpa_pkg::CNT_W'(1);
					ex_raddr = rpa_pkg::page_addr(ex_idx);
					ex_cnt   = rpa_pkg::CNT_W'(1);
				end else begin
					ex_status = rpa_pkg::STS_NO_PAGE;
				end
			end
			rpa_pkg::FN_RELEASE: begin
				if (bad_s1) begin
					ex_status = rpa_pkg::STS_BAD_ADDR;
				end else if (cnt_rdata == '0) begin
					ex_status = rpa_pkg::STS_ZERO;
				end else begin
					ex_we    = 1'b1;
					ex_wdata = cnt_rdata - rpa_pkg::CNT_W'(1);
					ex_cnt   = ex_wdata;
					ex_rel   = (ex_wdata == '0);
					ex_push  = ex_rel && (stack_depth_q < rpa_pkg::STACK_MAX);
				end
			end
			rpa_pkg::FN_SHARE, rpa_pkg::FN_QUERY: begin
				if (bad_s1) begin
					ex_status = rpa_pkg::STS_BAD_ADDR;
				end else begin
					if (func_s1 == rpa_pkg::FN_SHARE && cnt_rdata != rpa_pkg::CNT_MAX) begin
						ex_wdata = cnt_rdata + rpa_pkg::CNT_W'(1);
					end
					ex_we  = (func_s1 == rpa_pkg::FN_SHARE);
					ex_cnt = ex_wdata;
				end
			end
			default: begin
				ex_status = rpa_pkg::STS_OK;
			end
		endcase
	end

	// count store write port: clearing pass or execute write-back
	always_comb begin
		if (state_q == S_CLEAR) begin
			cnt_we    = 1'b1;
			cnt_waddr = clr_q;
			cnt_wdata = '0;
		end else begin
			cnt_we    = exec_fire && ex_we;
			cnt_waddr = ex_idx;
			cnt_wdata = ex_wdata;
		end
		stk_we    = exec_fire && ex_push;
		stk_waddr = stack_depth_q[rpa_pkg::IDX_W-1:0];
	end

	rpa_ram #(
		.WIDTH(rpa_pkg::CNT_W),
		.DEPTH(rpa_pkg::MEM_PAGES)
	) u_count_ram (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(cnt_waddr),
		.wdata(cnt_wdata),
		.re   (in_fire),
		.raddr(idx_in),
		.rdata(cnt_rdata)
	);

	rpa_ram #(
		.WIDTH(rpa_pkg::IDX_W),
		.DEPTH(rpa_pkg::MEM_PAGES)
	) u_stack_ram (
		.clk  (clk),
		.we   (stk_we),
		.waddr(stk_waddr),
		.wdata(ex_idx),
		.re   (in_fire),
		.raddr(stk_raddr),
		.rdata(stk_rdata)
	);

	// sequencer and allocator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_CLEAR;
			clr_q            <= '0;
			kernel_end_q     <= rpa_pkg::KEND_RST;
			floor_q          <= rpa_pkg::floor_page(rpa_pkg::KEND_RST);
			stack_depth_q    <= '0;
			next_untouched_q <= rpa_pkg::LAST_IDX;
			untouched_left_q <= 1'b1;
		end else begin
			if (cfg_valid && cfg_ready) begin
				kernel_end_q <= cfg_data;
				floor_q      <= rpa_pkg::floor_page(cfg_data);
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + rpa_pkg::IDX_W'(1);
					if (clr_q == rpa_pkg::LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (exec_fire) begin
						state_q <= S_IDLE;
						if (ex_pop) begin
							stack_depth_q <= depth_dec;
						end else if (ex_push) begin
							stack_depth_q <= stack_depth_q + rpa_pkg::DEPTH_W'(1);
						end
						if (ex_take) begin
							if (next_untouched_q == '0) begin
								untouched_left_q <= 1'b0;
							end else begin
								next_untouched_q <= next_untouched_q - rpa_pkg::IDX_W'(1);
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register: payload
	always_ff @(posedge clk) begin
		if (exec_fire) begin
			status_q         <= ex_status;
			result_address_q <= ex_raddr;
			share_count_q    <= ex_cnt;
			page_released_q  <= ex_rel;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign result_address = result_address_q;
	assign share_count    = share_count_q;
	assign page_released  = page_released_q;

	// stack never holds more than one entry per page
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stack_depth_q <= rpa_pkg::STACK_MAX)
		else $error("free stack depth above page count");

	// an accepted beat always moves to execute
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == S_EXEC))
		else $error("accepted beat did not enter execute");

	// no beat is accepted during the clearing pass
	a_clear_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !in_ready)
		else $error("input ready during clearing pass");

	// a released page reports a zero count and ok status
	a_release_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && page_released) |->
			(share_count == '0 && status == rpa_pkg::STS_OK))
		else $error("page released with nonzero count or error");

	// pop and push never happen together; a pop needs a non-empty stack
	a_stack_ops: assert property (@(posedge clk) disable iff (!arst_n)
		exec_fire |-> !(ex_pop && ex_push) && (!ex_pop || stack_depth_q != '0))
		else $error("inconsistent free stack operation");

endmodule
